### src/bfie_pkg.sv
// Shared types and constants for the bit field insert/extract block.
package bfie_pkg;

  // Field limits and the widest span that one field can touch (nine bytes).
  localparam int unsigned MAX_FIELD_BITS = 64;
  localparam int unsigned SPAN_BITS      = 72;
  localparam int unsigned CFG_W          = 9;
  localparam logic [CFG_W-1:0] BYTES_IN_USE_RESET = 9'd256;

  // Action codes.
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic        action;
    logic [7:0]  byte_position;
    logic [2:0]  bit_position;
    logic [6:0]  field_width;
    logic [63:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic        status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic load;
    logic setup;
    logic access;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic skip;
    logic access_done;
  } dp_status_t;

endpackage

### src/bit_field_insert_extract.sv
// Top level of the MSB-first bit field insert/extract block.
//
// Usage: an item (read or write of a 1 to 64 bit field) is transferred on a
// rising edge with start high and busy low. Its result appears on result,
// marked by done for exactly one cycle; the receiver cannot hold it off.
// Bits are numbered MSB-first in each byte of a byte-wide store.
// The user must write the bytes_in_use register through cfg_write/cfg_data
// only while idle; the block itself does not enforce it.
// A field touching n bytes (n = 1..9) keeps busy high through a setup step,
// a store pass paced by its single-byte read and write ports (per byte one
// read and, on a write, one write-back; read data registered) and a finish
// step; done follows in the next cycle, while a new item may already be
// taken. An out-of-range or zero-width item skips the store pass.
// Reset: rst (synchronous) sets bytes_in_use to 256 and starts a clearing
// pass that writes zero to every byte, one byte per cycle; busy stays high
// until it ends, configuration is taken.
module bit_field_insert_extract
  import bfie_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_item_t         item,
  output logic             done,
  output out_item_t        result,
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  bfie_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (dp_status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  bfie_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .status    (dp_status),
    .result    (result)
  );

  // An accepted item keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after an item transfer");

  // Each result strobe lasts one cycle.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // A result only ever follows a busy cycle.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding work");

  // An error result carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == STATUS_ERR)) |-> (result.read_value == 64'd0))
    else $error("error result with nonzero read value");

endmodule

### src/bfie_ctrl.sv
// Controller state machine for the bit field insert/extract block.
module bfie_ctrl
  import bfie_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SETUP  = 3'd2;
  localparam logic [2:0] ST_ACCESS = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and command decode.
  always_comb begin
    state_next     = state;
    cmd            = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = status.skip ? ST_FINISH : ST_ACCESS;
      end
      ST_ACCESS: begin
        cmd.access = 1'b1;
        if (status.access_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register and the result strobe, which follows the finish step.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

### src/bfie_datapath.sv
// Datapath: byte store, field alignment, byte sequencing and result register.
module bfie_datapath
  import bfie_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_data,
  input  in_item_t         item,
  input  ctrl_cmd_t        cmd,
  output dp_status_t       status,
  output out_item_t        result
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  // Saturation cap for the register; above 511 it can never saturate.
  localparam logic [9:0] BB_CAP = (BUFFER_BYTES > 511) ? 10'd511 : 10'(BUFFER_BYTES);

  logic [7:0]           mem [BUFFER_BYTES];
  logic [CFG_W-1:0]     bytes_in_use;
  in_item_t             item_r;
  logic [AW-1:0]        clear_addr;
  logic [3:0]           n_bytes;
  logic [2:0]           tail;
  logic                 err_r;
  logic [SPAN_BITS-1:0] pattern;
  logic [SPAN_BITS-1:0] wmask;
  logic [SPAN_BITS-1:0] acc;
  logic [3:0]           issue_cnt;
  logic                 pending;
  logic [AW-1:0]        wb_addr;
  logic [7:0]           q;

  logic [63:0]          field_mask;
  logic [9:0]           limit;
  logic [12:0]          field_end;
  logic                 err;
  logic [7:0]           bit_sum;
  logic [7:0]           shift_amt;
  logic                 issue;
  logic [AW-1:0]        raddr;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [7:0]           mem_wdata;
  logic [SPAN_BITS-1:0] acc_shifted;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_use <= BYTES_IN_USE_RESET;
    end else if (cfg_write) begin
      bytes_in_use <= cfg_data;
    end
  end

  // Field mask, range check and span geometry from the captured item.
  always_comb begin
    field_mask = 64'((65'd1 << item_r.field_width) - 65'd1);
    limit      = ({1'b0, bytes_in_use} > BB_CAP) ? BB_CAP : {1'b0, bytes_in_use};
    field_end  = 13'({item_r.byte_position, item_r.bit_position})
               + 13'(item_r.field_width);
    err        = (item_r.field_width > 7'(MAX_FIELD_BITS))
               || (field_end > {limit, 3'b000});
    bit_sum    = 8'(item_r.bit_position) + 8'(item_r.field_width);
    shift_amt  = 8'(SPAN_BITS) - bit_sum;
  end

  assign status.skip = err || (item_r.field_width == 7'd0);

  // Byte issue and read address for the current step.
  assign issue = cmd.access && (issue_cnt != n_bytes);
  assign raddr = AW'({1'b0, item_r.byte_position} + 9'(issue_cnt));
  assign status.access_done = (issue_cnt == n_bytes) && pending;
  assign status.clear_last  = (clear_addr == AW'(BUFFER_BYTES - 1));

  // Capture, setup and byte sequencing.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= item;
    end
    if (cmd.setup) begin
      n_bytes   <= 4'((bit_sum + 8'd7) >> 3);
      tail      <= 3'(8'd0 - bit_sum);
      err_r     <= err;
      pattern   <= SPAN_BITS'(item_r.write_value & field_mask) << shift_amt;
      wmask     <= SPAN_BITS'(field_mask) << shift_amt;
      acc       <= '0;
      issue_cnt <= '0;
    end else begin
      if (issue) begin
        issue_cnt <= issue_cnt + 4'd1;
        wb_addr   <= raddr;
      end
      if (cmd.access && pending) begin
        acc     <= {acc[SPAN_BITS-9:0], q};
        pattern <= pattern << 8;
        wmask   <= wmask << 8;
      end
    end
  end

  // Read-data valid flag and the clearing pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= 1'b0;
      clear_addr <= '0;
    end else begin
      pending <= issue;
      if (cmd.clear_step) begin
        clear_addr <= clear_addr + AW'(1);
      end
    end
  end

  // Write port: zeros during the clearing pass, merged bytes on a field write.
  always_comb begin
    mem_we    = cmd.clear_step
              || (cmd.access && pending && (item_r.action == ACT_WRITE));
    mem_waddr = cmd.clear_step ? clear_addr : wb_addr;
    mem_wdata = cmd.clear_step ? 8'h00
              : ((q & ~wmask[SPAN_BITS-1 -: 8]) | pattern[SPAN_BITS-1 -: 8]);
  end

  // Byte store with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    q <= mem[raddr];
  end

  // Right-align the gathered bytes and register the result.
  assign acc_shifted = acc >> tail;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.status     <= err_r ? STATUS_ERR : STATUS_OK;
      result.read_value <= (!err_r && (item_r.action == ACT_READ))
                         ? (acc_shifted[63:0] & field_mask) : 64'd0;
    end
  end

endmodule
